FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; clock clk, synchronous active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/gbn_pkg.sv
// Types, constants and sequencer states of the greedy box suppression block.
package gbn_pkg;

  localparam int MAX_BOXES = 64;
  localparam logic [15:0] IOU_LIMIT_RESET = 16'd29491;

  typedef struct packed {
    logic signed [15:0] left_edge;
    logic signed [15:0] top_edge;
    logic signed [15:0] right_edge;
    logic signed [15:0] bottom_edge;
    logic [15:0]        score;
    logic [7:0]         class_tag;
    logic               final_box;
  } box_in_t;

  typedef struct packed {
    logic signed [15:0] kept_left;
    logic signed [15:0] kept_top;
    logic signed [15:0] kept_right;
    logic signed [15:0] kept_bottom;
    logic [15:0]        kept_score;
    logic [7:0]         kept_class;
    logic               last_kept;
    logic               overflowed;
  } box_out_t;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic [15:0]        score;
    logic [7:0]         cls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_EMIT,
    S_LOAD_RD,
    S_LOAD_WAIT,
    S_AREA,
    S_SUP_RD,
    S_SUP_GEO,
    S_SUP_INT,
    S_SUP_AREA,
    S_SUP_UNI,
    S_SUP_LIM,
    S_SUP_CMP,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/greedy_box_nms.sv
// Greedy IoU non-maximum suppression: box store, shared multiplier and sequencer.
// The block takes a non-final box while idle and stalls input while a set is resolved.
// Per kept box: a score scan over the live entries, then one pass over the store that
// runs each live entry through the single shared multiplier and drops it when its IoU
// with the kept box reaches the threshold; output backpressure adds waits.
// Synchronous active-low reset clears control state and sets the threshold to 29491.
`include "assert_macros.svh"

module greedy_box_nms #(
  parameter int MAX_BOXES = gbn_pkg::MAX_BOXES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gbn_pkg::box_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output gbn_pkg::box_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  gbn_pkg::state_t state_r, state_nxt;

  logic [15:0]          limit_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        idx_r;
  logic                 ovf_r;
  logic [MAX_BOXES-1:0] dropped_r;
  logic                 best_found_r;
  logic [AW-1:0]        best_idx_r;
  logic [15:0]          best_score_r;
  logic                 pend_valid_r;
  gbn_pkg::entry_t      pend_r;
  logic                 out_valid_r;
  gbn_pkg::box_out_t    out_data_r;

  logic signed [16:0]   w_r, h_r;
  logic signed [35:0]   inter_r, area_a_r, area_b_r;
  logic signed [37:0]   uni_r;
  logic signed [55:0]   prod_r;

  logic                 in_acc;
  logic                 at_end;
  logic                 cur_dropped;
  logic                 out_go;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [gbn_pkg::ENTRY_W-1:0] ram_rdata;
  gbn_pkg::entry_t      rd_e, wr_e;

  logic signed [37:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [55:0]   mul_p;

  logic signed [16:0]   pdx, pdy, bdx, bdy, w_c, h_c;
  logic signed [15:0]   ix1, iy1, ix2, iy2;
  logic signed [55:0]   lhs;
  logic                 suppress;

  assign in_stall  = (state_r != gbn_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign at_end      = (idx_r == count_r);
  assign cur_dropped = dropped_r[idx_r[AW-1:0]];
  assign out_go      = !out_valid_r || !out_stall;

  assign wr_e.x1    = in_data.left_edge;
  assign wr_e.y1    = in_data.top_edge;
  assign wr_e.x2    = in_data.right_edge;
  assign wr_e.y2    = in_data.bottom_edge;
  assign wr_e.score = in_data.score;
  assign wr_e.cls   = in_data.class_tag;
  assign rd_e       = gbn_pkg::entry_t'(ram_rdata);

  assign ram_we    = in_acc && (count_r < CW'(MAX_BOXES));
  assign ram_re    = (state_r == gbn_pkg::S_LOAD_RD) ||
                     (((state_r == gbn_pkg::S_SCAN_RD) || (state_r == gbn_pkg::S_SUP_RD)) &&
                      !at_end && !cur_dropped);
  assign ram_raddr = (state_r == gbn_pkg::S_LOAD_RD) ? best_idx_r : idx_r[AW-1:0];

  gbn_ram #(
    .WIDTH (gbn_pkg::ENTRY_W),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_e),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // geometry of the kept box against the entry just read
  always_comb begin
    pdx = 17'(pend_r.x2) - 17'(pend_r.x1);
    pdy = 17'(pend_r.y2) - 17'(pend_r.y1);
    bdx = 17'(rd_e.x2) - 17'(rd_e.x1);
    bdy = 17'(rd_e.y2) - 17'(rd_e.y1);
    ix1 = (pend_r.x1 > rd_e.x1) ? pend_r.x1 : rd_e.x1;
    iy1 = (pend_r.y1 > rd_e.y1) ? pend_r.y1 : rd_e.y1;
    ix2 = (pend_r.x2 < rd_e.x2) ? pend_r.x2 : rd_e.x2;
    iy2 = (pend_r.y2 < rd_e.y2) ? pend_r.y2 : rd_e.y2;
    w_c = 17'(ix2) - 17'(ix1);
    h_c = 17'(iy2) - 17'(iy1);
    if (w_c < 0) begin
      w_c = '0;
    end
    if (h_c < 0) begin
      h_c = '0;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 38'(w_r);
    mul_b = 18'(h_r);
    case (state_r)
      gbn_pkg::S_AREA: begin
        mul_a = 38'(pdx);
        mul_b = 18'(pdy);
      end
      gbn_pkg::S_SUP_AREA: begin
        mul_a = 38'(bdx);
        mul_b = 18'(bdy);
      end
      gbn_pkg::S_SUP_LIM: begin
        mul_a = uni_r;
        mul_b = $signed({2'b00, limit_r});
      end
      default: begin
        mul_a = 38'(w_r);
        mul_b = 18'(h_r);
      end
    endcase
  end

  assign mul_p    = 56'(mul_a) * 56'(mul_b);
  assign lhs      = {{4{inter_r[35]}}, inter_r, 16'h0000};
  assign suppress = !(lhs < prod_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbn_pkg::S_IDLE: begin
        if (in_acc && in_data.final_box) begin
          state_nxt = gbn_pkg::S_SCAN_RD;
        end
      end
      gbn_pkg::S_SCAN_RD: begin
        if (at_end) begin
          if (pend_valid_r) begin
            state_nxt = gbn_pkg::S_EMIT;
          end else if (best_found_r) begin
            state_nxt = gbn_pkg::S_LOAD_RD;
          end else begin
            state_nxt = gbn_pkg::S_DONE;
          end
        end else if (!cur_dropped) begin
          state_nxt = gbn_pkg::S_SCAN_CMP;
        end
      end
      gbn_pkg::S_SCAN_CMP:  state_nxt = gbn_pkg::S_SCAN_RD;
      gbn_pkg::S_EMIT: begin
        if (out_go) begin
          state_nxt = best_found_r ? gbn_pkg::S_LOAD_RD : gbn_pkg::S_DONE;
        end
      end
      gbn_pkg::S_LOAD_RD:   state_nxt = gbn_pkg::S_LOAD_WAIT;
      gbn_pkg::S_LOAD_WAIT: state_nxt = gbn_pkg::S_AREA;
      gbn_pkg::S_AREA:      state_nxt = gbn_pkg::S_SUP_RD;
      gbn_pkg::S_SUP_RD: begin
        if (at_end) begin
          state_nxt = gbn_pkg::S_SCAN_RD;
        end else if (!cur_dropped) begin
          state_nxt = gbn_pkg::S_SUP_GEO;
        end
      end
      gbn_pkg::S_SUP_GEO:   state_nxt = gbn_pkg::S_SUP_INT;
      gbn_pkg::S_SUP_INT:   state_nxt = gbn_pkg::S_SUP_AREA;
      gbn_pkg::S_SUP_AREA:  state_nxt = gbn_pkg::S_SUP_UNI;
      gbn_pkg::S_SUP_UNI:   state_nxt = gbn_pkg::S_SUP_LIM;
      gbn_pkg::S_SUP_LIM:   state_nxt = gbn_pkg::S_SUP_CMP;
      gbn_pkg::S_SUP_CMP:   state_nxt = gbn_pkg::S_SUP_RD;
      gbn_pkg::S_DONE:      state_nxt = gbn_pkg::S_IDLE;
      default:              state_nxt = gbn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gbn_pkg::S_IDLE;
      limit_r      <= gbn_pkg::IOU_LIMIT_RESET;
      count_r      <= '0;
      idx_r        <= '0;
      ovf_r        <= 1'b0;
      dropped_r    <= '0;
      best_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      case (state_r)
        gbn_pkg::S_IDLE: begin
          if (in_acc) begin
            if (ram_we) begin
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            idx_r        <= '0;
            best_found_r <= 1'b0;
          end
        end
        gbn_pkg::S_SCAN_RD: begin
          if (!at_end && cur_dropped) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        gbn_pkg::S_SCAN_CMP: begin
          if (!best_found_r || (rd_e.score > best_score_r)) begin
            best_found_r <= 1'b1;
            best_idx_r   <= idx_r[AW-1:0];
            best_score_r <= rd_e.score;
          end
          idx_r <= idx_r + 1'b1;
        end
        gbn_pkg::S_EMIT: begin
          if (out_go) begin
            pend_valid_r <= 1'b0;
          end
        end
        gbn_pkg::S_LOAD_RD: begin
          dropped_r[best_idx_r] <= 1'b1;
        end
        gbn_pkg::S_LOAD_WAIT: begin
          pend_r       <= rd_e;
          pend_valid_r <= 1'b1;
        end
        gbn_pkg::S_AREA: begin
          idx_r <= '0;
        end
        gbn_pkg::S_SUP_RD: begin
          if (at_end) begin
            idx_r        <= '0;
            best_found_r <= 1'b0;
          end else if (cur_dropped) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        gbn_pkg::S_SUP_CMP: begin
          if (suppress) begin
            dropped_r[idx_r[AW-1:0]] <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        gbn_pkg::S_DONE: begin
          count_r      <= '0;
          ovf_r        <= 1'b0;
          dropped_r    <= '0;
          pend_valid_r <= 1'b0;
          best_found_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    case (state_r)
      gbn_pkg::S_AREA:     area_a_r <= mul_p[35:0];
      gbn_pkg::S_SUP_GEO: begin
        w_r <= w_c;
        h_r <= h_c;
      end
      gbn_pkg::S_SUP_INT:  inter_r  <= mul_p[35:0];
      gbn_pkg::S_SUP_AREA: area_b_r <= mul_p[35:0];
      gbn_pkg::S_SUP_UNI:  uni_r    <= 38'(area_a_r) + 38'(area_b_r) - 38'(inter_r);
      gbn_pkg::S_SUP_LIM:  prod_r   <= mul_p;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == gbn_pkg::S_EMIT) && out_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == gbn_pkg::S_EMIT) && out_go) begin
      out_data_r.kept_left   <= pend_r.x1;
      out_data_r.kept_top    <= pend_r.y1;
      out_data_r.kept_right  <= pend_r.x2;
      out_data_r.kept_bottom <= pend_r.y2;
      out_data_r.kept_score  <= pend_r.score;
      out_data_r.kept_class  <= pend_r.cls;
      out_data_r.last_kept   <= !best_found_r;
      out_data_r.overflowed  <= ovf_r;
    end
  end

  `ASSERT_ALWAYS(a_count_range, count_r <= CW'(MAX_BOXES), "box count beyond capacity")
  `ASSERT_IMP(a_idle_clean, state_r == gbn_pkg::S_IDLE, dropped_r == '0 && !pend_valid_r, "stale set state in idle")
  `ASSERT_NEXT(a_last_done, state_r == gbn_pkg::S_EMIT && out_go && !best_found_r, state_r == gbn_pkg::S_DONE, "last result not followed by set end")
  `ASSERT_IMP(a_emit_pending, state_r == gbn_pkg::S_EMIT, pend_valid_r, "emit without pending box")

endmodule
